FILE: rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTYDEL = 3'd2;
  localparam logic [2:0] ST_ENTRY    = 3'd3;
  localparam logic [2:0] ST_EMPTYDMP = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  // Broadcast to every cell in the chain each cycle.
  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] tail;
  } cell_ctrl_t;

endpackage

FILE: rtl/positional_list_engine.sv
// Top level of the positional list engine: control, fill count and the cell chain.
// Insert, delete and unused commands: the result is in the output register in the cycle after the transfer.
// A new item may follow every cycle while the result side keeps taking transfers.
// Dump: enters the dump state, then one entry per cycle from the head while results are taken.
// The chain rotates once per dumped entry and is back in order when the dump ends.
// Synchronous reset empties the list; the cell contents stay undefined until written.
module positional_list_engine #(
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              command,
  input  logic [ple_pkg::POS_W-1:0]               position,
  input  logic signed [ple_pkg::DATA_W-1:0]       value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [ple_pkg::DATA_W-1:0]       element,
  output logic [$clog2(DEPTH+1)-1:0]              count,
  output logic                                    last,
  output logic [2:0]                              status
);
  import ple_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                     state;
  logic [CW-1:0]            fill;
  logic [IW-1:0]            didx;
  logic signed [DATA_W-1:0] q [DEPTH];
  cell_ctrl_t               ctrl;

  logic             take;
  logic             out_free;
  logic             emit_dump;
  logic             res_load;
  logic             full;
  logic             empty;
  logic             dump_last;
  logic [POS_W-1:0] fill_ext;
  logic [POS_W-1:0] tail;
  logic [POS_W-1:0] ins_pos;
  logic [POS_W-1:0] del_pos;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign take      = in_valid && in_ready;
  assign emit_dump = (state == S_DUMP) && out_free;
  // A dump of a non-empty list loads no result at its own transfer.
  assign res_load  = emit_dump || (take && !(command == CMD_DUMP && !empty));
  assign full      = (fill == CW'(DEPTH));
  assign empty     = (fill == '0);
  assign fill_ext  = POS_W'(fill);
  assign tail      = fill_ext - POS_W'(1);
  assign ins_pos   = (position < fill_ext) ? position : fill_ext;
  assign del_pos   = (position < tail) ? position : tail;
  assign dump_last = (POS_W'(didx) == tail);

  always_comb begin
    ctrl.op   = OP_HOLD;
    ctrl.pos  = ins_pos;
    ctrl.tail = tail;
    if (take && command == CMD_INSERT && !full) begin
      ctrl.op = OP_INSERT;
    end else if (take && command == CMD_DELETE && !empty) begin
      ctrl.op  = OP_DELETE;
      ctrl.pos = del_pos;
    end else if (emit_dump) begin
      ctrl.op = OP_ROTATE;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = q[i+1];
    end
    ple_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .left (left_d),
      .right(right_d),
      .head (q[0]),
      .value(value),
      .q    (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      didx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        element <= '0;
        last    <= 1'b1;
        case (command)
          CMD_INSERT: begin
            if (full) begin
              status <= ST_FULL;
              count  <= fill;
            end else begin
              status <= ST_DONE;
              count  <= fill + CW'(1);
              fill   <= fill + CW'(1);
            end
          end
          CMD_DELETE: begin
            if (empty) begin
              status <= ST_EMPTYDEL;
              count  <= fill;
            end else begin
              status <= ST_DONE;
              count  <= fill - CW'(1);
              fill   <= fill - CW'(1);
            end
          end
          CMD_DUMP: begin
            if (empty) begin
              status    <= ST_EMPTYDMP;
              count     <= fill;
            end else begin
              state <= S_DUMP;
              didx  <= '0;
            end
          end
          default: begin
            status    <= ST_DONE;
            count     <= fill;
          end
        endcase
      end
      if (emit_dump) begin
        element   <= q[0];
        count     <= fill;
        last      <= dump_last;
        status    <= ST_ENTRY;
        didx      <= didx + IW'(1);
        if (dump_last) begin
          state <= S_IDLE;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_mid_dump: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (state == S_DUMP && status == ST_ENTRY))
    else $error("non-final result outside a dump");

  a_dump_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP) |=> $stable(fill))
    else $error("fill count changed during a dump");

  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (take && command == CMD_INSERT && full) |=>
      (out_valid && status == ST_FULL && fill == CW'(DEPTH)))
    else $error("insert into a full list not dropped");

endmodule

FILE: rtl/ple_cell.sv
// One storage cell of the list chain, taking data from either neighbour, the new value or the head.
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  ple_pkg::cell_ctrl_t                 ctrl,
  input  logic signed [ple_pkg::DATA_W-1:0]   left,
  input  logic signed [ple_pkg::DATA_W-1:0]   right,
  input  logic signed [ple_pkg::DATA_W-1:0]   head,
  input  logic signed [ple_pkg::DATA_W-1:0]   value,
  output logic signed [ple_pkg::DATA_W-1:0]   q
);
  import ple_pkg::*;

  localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    q_next = q;
    case (ctrl.op)
      OP_INSERT: begin
        if (IDX_P > ctrl.pos) begin
          q_next = left;
        end else if (IDX_P == ctrl.pos) begin
          q_next = value;
        end
      end
      OP_DELETE: begin
        if (IDX_P >= ctrl.pos) begin
          q_next = right;
        end
      end
      OP_ROTATE: begin
        // The held entries turn round by one so the head can be read out.
        if (IDX_P < ctrl.tail) begin
          q_next = right;
        end else if (IDX_P == ctrl.tail) begin
          q_next = head;
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the positional list engine: directed table, then random traffic.
module testbench;
  import ple_pkg::*;

  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIMIT = 600000;
  localparam int RANDOM_ITEMS = 160;
  localparam int PRESSURE_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
    logic [2:0]               status;
  } list_result_t;

  // A row with typed set carries its own expected count and status; the rest are predicted.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              typed;
    logic [CNT_W-1:0]  count;
    logic [2:0]        status;
  } list_row_t;

  list_row_t directed_rows [22] = '{
    '{CMD_DELETE, 8'd0,   32'h0000_0000, 1'b1, 6'd0, ST_EMPTYDEL},
    '{CMD_DUMP,   8'd0,   32'h0000_0000, 1'b1, 6'd0, ST_EMPTYDMP},
    '{CMD_UNUSED, 8'hA5,  32'h5A5A_5A5A, 1'b1, 6'd0, ST_DONE},
    '{CMD_INSERT, 8'd255, 32'h7FFF_FFFF, 1'b1, 6'd1, ST_DONE},
    '{CMD_INSERT, 8'd0,   32'h8000_0000, 1'b1, 6'd2, ST_DONE},
    '{CMD_INSERT, 8'd1,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_INSERT, 8'd2,   32'hFFFF_FFFF, 1'b0, 6'd0, ST_DONE},
    '{CMD_INSERT, 8'd3,   32'h1357_9BDF, 1'b0, 6'd0, ST_DONE},
    '{CMD_DUMP,   8'd0,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DELETE, 8'd0,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DUMP,   8'd17,  32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DELETE, 8'd255, 32'hFFFF_FFFF, 1'b0, 6'd0, ST_DONE},
    '{CMD_DELETE, 8'd1,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DUMP,   8'd0,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DELETE, 8'd0,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DELETE, 8'd200, 32'h0000_0000, 1'b1, 6'd0, ST_DONE},
    '{CMD_DELETE, 8'd0,   32'h0000_0000, 1'b1, 6'd0, ST_EMPTYDEL},
    '{CMD_INSERT, 8'd9,   32'h2468_ACE0, 1'b1, 6'd1, ST_DONE},
    '{CMD_DUMP,   8'd0,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_INSERT, 8'd0,   32'hDEAD_BEEF, 1'b0, 6'd0, ST_DONE},
    '{CMD_DUMP,   8'd0,   32'h0000_0000, 1'b0, 6'd0, ST_DONE},
    '{CMD_DUMP,   8'd255, 32'hFFFF_FFFF, 1'b0, 6'd0, ST_DONE}
  };

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] element;
  logic [CNT_W-1:0]         count;
  logic                     last;
  logic [2:0]               status;

  // Shadow copy of the list, advanced as each input transfer is accepted.
  logic signed [DATA_W-1:0] list_words [DEPTH];
  int                       list_len;
  list_result_t             staged_results[$];
  list_result_t             awaited_results[$];

  int mismatches;
  int send_idle;
  int recv_idle;
  int cycle_count;
  bit squeeze;
  bit squeeze_done;

  positional_list_engine #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .element   (element),
    .count     (count),
    .last      (last),
    .status    (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void stage_result(logic signed [DATA_W-1:0] elem, logic fin,
                                       logic [2:0] st);
    staged_results.push_back('{elem, CNT_W'(list_len), fin, st});
  endfunction

  function automatic void apply_command(logic [1:0] cmd, logic [POS_W-1:0] pos,
                                        logic signed [DATA_W-1:0] val);
    int slot;
    staged_results.delete();
    case (cmd)
      CMD_INSERT: begin
        if (list_len >= DEPTH) begin
          stage_result('0, 1'b1, ST_FULL);
        end else begin
          slot = (int'(pos) < list_len) ? int'(pos) : list_len;
          for (int i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
          list_words[slot] = val;
          list_len++;
          stage_result('0, 1'b1, ST_DONE);
        end
      end
      CMD_DELETE: begin
        if (list_len == 0) begin
          stage_result('0, 1'b1, ST_EMPTYDEL);
        end else begin
          slot = (int'(pos) < list_len - 1) ? int'(pos) : list_len - 1;
          for (int i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          stage_result('0, 1'b1, ST_DONE);
        end
      end
      CMD_DUMP: begin
        if (list_len == 0) begin
          stage_result('0, 1'b1, ST_EMPTYDMP);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            stage_result(list_words[i], (i + 1 == list_len), ST_ENTRY);
          end
        end
      end
      default: begin
        stage_result('0, 1'b1, ST_DONE);
      end
    endcase
  endfunction

  // Entered and left at a falling edge; holds the item until its transfer.
  task automatic send_item(list_row_t row);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    command  <= row.cmd;
    position <= row.pos;
    value    <= row.val;
    do @(posedge clk); while (!in_ready);
    apply_command(row.cmd, row.pos, row.val);
    if (row.typed) begin
      awaited_results.push_back('{'0, row.count, 1'b1, row.status});
    end else begin
      foreach (staged_results[k]) awaited_results.push_back(staged_results[k]);
    end
    @(negedge clk);
  endtask

  initial begin
    list_row_t row;
    bit        fill_mode;
    int        pick;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_INSERT;
    position = '0;
    value = '0;
    list_len = 0;
    mismatches = 0;
    send_idle = 32;
    recv_idle = 82;
    squeeze = 1'b0;
    fill_mode = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[k]) send_item(directed_rows[k]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle = 82;
        recv_idle = 32;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle = 0;
        recv_idle = 0;
        squeeze = 1'b1;
      end
      // Swing between filling and draining so that both the full and empty cases recur.
      if (list_len == DEPTH && fill_mode && $urandom_range(0, 2) == 0) fill_mode = 1'b0;
      if (list_len == 0 && !fill_mode && $urandom_range(0, 2) == 0) fill_mode = 1'b1;
      row = '0;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        row.cmd = CMD_UNUSED;
      end else if (pick < 14) begin
        row.cmd = CMD_DUMP;
      end else if (($urandom_range(0, 99) < 85) == fill_mode) begin
        row.cmd = CMD_INSERT;
      end else begin
        row.cmd = CMD_DELETE;
      end
      if ($urandom_range(0, 3) == 0) begin
        row.pos = POS_W'($urandom_range(0, 255));
      end else begin
        row.pos = POS_W'($urandom_range(0, list_len + 1));
      end
      case ($urandom_range(0, 9))
        0:       row.val = 32'h8000_0000;
        1:       row.val = 32'h7FFF_FFFF;
        default: row.val = $urandom();
      endcase
      send_item(row);
    end
    in_valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off so that the block backs up.
  initial begin
    out_ready = 1'b0;
    squeeze_done = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze && !squeeze_done) begin
        out_ready <= 1'b0;
        for (int c = 0; c < PRESSURE_CYCLES; c++) @(negedge clk);
        squeeze_done = 1'b1;
      end else begin
        out_ready <= (rst == 1'b0) && ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    list_result_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("unexpected result: element %0d count %0d last %0b status %0d",
                     element, count, last, status);
          end
        end else begin
          want = awaited_results.pop_front();
          if (element !== want.element || count !== want.count ||
              last !== want.last || status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch: expected element %0d count %0d last %0b status %0d",
                       want.element, want.count, want.last, want.status);
              $display("          got      element %0d count %0d last %0b status %0d",
                       element, count, last, status);
            end
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/positional_list_engine.sv
tb/sv/testbench.sv
